### rtl/exlex_pkg.sv
// Shared types, constants and character-class helpers for the expression lexer.
package exlex_pkg;

  localparam int POS_W   = 16;   // byte position counter width (8..32)
  localparam int START_W = 16;   // token start offset width
  localparam int LEN_W   = 16;   // token length width
  localparam int KIND_W  = 4;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // keyword matcher progress: 0..4 letters matched, or mismatch
  localparam logic [2:0] KW_DONE     = 3'd4;
  localparam logic [2:0] KW_MISMATCH = 3'd7;

  typedef enum logic [KIND_W-1:0] {
    TK_END     = 4'd0,
    TK_IDENT   = 4'd1,
    TK_WITH    = 4'd2,
    TK_NUMBER  = 4'd3,
    TK_PLUS    = 4'd4,
    TK_MINUS   = 4'd5,
    TK_STAR    = 4'd6,
    TK_SLASH   = 4'd7,
    TK_LPAREN  = 4'd8,
    TK_RPAREN  = 4'd9,
    TK_COLON   = 4'd10,
    TK_COMMA   = 4'd11,
    TK_UNKNOWN = 4'd12
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               last;
  } token_t;

  // tokens produced by one input byte (0, 1 or 2)
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } tok_push_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0C || c == 8'h0B ||
           c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  // letters of "with"
  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h77;
      2'd1:    ch = 8'h69;
      2'd2:    ch = 8'h74;
      default: ch = 8'h68;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_track(input logic [2:0] prog, input logic [7:0] c);
    logic [2:0] res;
    if (prog < KW_DONE && c == kw_char(prog[1:0])) begin
      res = prog + 3'd1;
    end else begin
      res = KW_MISMATCH;
    end
    return res;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_STAR;
      8'h2F:   k = TK_SLASH;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h3A:   k = TK_COLON;
      8'h2C:   k = TK_COMMA;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

### rtl/exlex_scan.sv
// Scanner: run state, position counter and token generation for one byte.
module exlex_scan
  import exlex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_in,
  output tok_push_t  push
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [2:0]         kw_r, kw_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  logic               letter, digit, space;
  logic [START_W-1:0] here;
  logic [LEN_W-1:0]   len_inc;
  token_t             flush_tok, new_tok;
  logic               have_flush, have_new;

  assign letter  = is_letter(byte_in);
  assign digit   = is_digit(byte_in);
  assign space   = is_space(byte_in);
  assign here    = START_W'(pos_r);
  assign len_inc = (len_r == LEN_MAX) ? len_r : len_r + LEN_W'(1);

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    kw_nxt     = kw_r;
    pos_nxt    = pos_r;
    have_flush = 1'b0;
    have_new   = 1'b0;

    flush_tok.kind  = TK_NUMBER;
    if (mode_r == MODE_IDENT) begin
      flush_tok.kind = (kw_r == KW_DONE) ? TK_WITH : TK_IDENT;
    end
    flush_tok.start = start_r;
    flush_tok.len   = len_r;
    flush_tok.last  = 1'b0;

    new_tok.kind  = single_kind(byte_in);
    new_tok.start = here;
    new_tok.len   = LEN_W'(1);
    new_tok.last  = 1'b1;

    if (byte_vld) begin
      if ((mode_r == MODE_IDENT && letter) || (mode_r == MODE_NUMBER && digit)) begin
        // run continues
        len_nxt = len_inc;
        if (mode_r == MODE_IDENT) begin
          kw_nxt = kw_track(kw_r, byte_in);
        end
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        have_flush = (mode_r != MODE_IDLE);
        mode_nxt   = MODE_IDLE;
        len_nxt    = '0;
        kw_nxt     = '0;
        if (byte_in == 8'h00) begin
          // end of input
          have_new     = 1'b1;
          new_tok.kind = TK_END;
          new_tok.len  = '0;
          start_nxt    = '0;
          pos_nxt      = '0;
        end else begin
          if (letter) begin
            mode_nxt  = MODE_IDENT;
            start_nxt = here;
            len_nxt   = LEN_W'(1);
            kw_nxt    = kw_track(3'd0, byte_in);
          end else if (digit) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = here;
            len_nxt   = LEN_W'(1);
          end else if (!space) begin
            have_new = 1'b1;
          end
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end

    // a lone token carries last; with two, only the second does
    push.push0 = have_flush || have_new;
    push.push1 = have_flush && have_new;
    push.tok0  = have_flush ? flush_tok : new_tok;
    if (have_flush && !have_new) begin
      push.tok0.last = 1'b1;
    end
    push.tok1 = new_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      len_r   <= '0;
      kw_r    <= '0;
      pos_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      kw_r    <= kw_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### rtl/expression_lexer.sv
// Top level of the expression lexer: byte stream in, token stream out.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[7:0] char_byte
//  out_    | out | out_tvalid/tready  | tdata start/length, tuser kind,
//          |     |                    | tlast = last token of the input word
//
// One input word is taken per clock while in_tready is high. Each word yields
// zero, one or two tokens, written into a four-entry token queue in the same
// cycle; the queue drains one token per clock while out_tready is high.
// in_tready drops while fewer than two queue slots are free, so a word that
// closes a run and makes its own token always finds two free slots. Reset
// (rst_n low, synchronous) clears the run state, the position and the queue.
module expression_lexer
  import exlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] token_start, [31:16] token_length
  output logic [3:0]  out_tuser,   // [3:0] token_kind
  output logic        out_tlast    // last token of the input word
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  logic      in_acc, out_acc;
  tok_push_t push;

  // token queue
  token_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  token_t              head;

  assign in_tready = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  exlex_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_acc),
    .byte_in  (in_tdata),
    .push     (push)
  );

  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = {head.len, head.start};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.push0) + QPTR_W'(push.push1);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(out_acc);
    cnt_nxt    = cnt_r + QCNT_W'(push.push0) + QCNT_W'(push.push1)
                 - QCNT_W'(out_acc);
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_mem[wr_ptr_r] <= push.tok0;
    end
    if (push.push1) begin
      q_mem[wr_ptr_r + QPTR_W'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the expression lexer: byte stream in, token stream checked out.
`timescale 1ns / 1ps

// Token scoreboard. It tracks the lexer state on its own, turns every accepted
// input byte into the tokens it must produce, and checks tokens in order.
class token_scoreboard;
  typedef enum logic [1:0] {RUN_NONE, RUN_WORD, RUN_DIGITS} run_e;

  localparam logic [31:0] KW_TEXT = "with";

  exlex_pkg::token_t expected_q[$];

  run_e                             mode;
  logic [exlex_pkg::START_W-1:0]    run_start;
  logic [exlex_pkg::LEN_W-1:0]      run_len;
  logic [2:0]                       kw_prog;
  logic [exlex_pkg::POS_W-1:0]      pos;

  int errors;
  int tokens_checked;
  int keywords;
  int end_marks;

  function new();
    mode      = RUN_NONE;
    run_start = '0;
    run_len   = '0;
    kw_prog   = '0;
    pos       = '0;
    errors    = 0;
    tokens_checked = 0;
    keywords  = 0;
    end_marks = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit alpha(logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    return low >= "a" && low <= "z";
  endfunction

  function bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit blank(logic [7:0] c);
    bit hit;
    case (c)
      " ", "\t", "\n", "\v", "\f", "\r": hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

  function exlex_pkg::kind_t punct_kind(logic [7:0] c);
    exlex_pkg::kind_t k;
    case (c)
      "+":     k = exlex_pkg::TK_PLUS;
      "-":     k = exlex_pkg::TK_MINUS;
      "*":     k = exlex_pkg::TK_STAR;
      "/":     k = exlex_pkg::TK_SLASH;
      "(":     k = exlex_pkg::TK_LPAREN;
      ")":     k = exlex_pkg::TK_RPAREN;
      ":":     k = exlex_pkg::TK_COLON;
      ",":     k = exlex_pkg::TK_COMMA;
      default: k = exlex_pkg::TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // keyword match is case sensitive and must cover the whole run
  function void step_keyword(logic [7:0] c);
    if (kw_prog < exlex_pkg::KW_DONE && c == KW_TEXT[31 - 8 * int'(kw_prog) -: 8]) begin
      kw_prog = kw_prog + 3'd1;
    end else begin
      kw_prog = exlex_pkg::KW_MISMATCH;
    end
  endfunction

  function void push_token(exlex_pkg::kind_t k, logic [exlex_pkg::START_W-1:0] s,
                           logic [exlex_pkg::LEN_W-1:0] l);
    exlex_pkg::token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.last  = 1'b0;
    if (k == exlex_pkg::TK_WITH) keywords++;
    if (k == exlex_pkg::TK_END) end_marks++;
    expected_q.push_back(t);
  endfunction

  function void note_byte(logic [7:0] c);
    logic [exlex_pkg::START_W-1:0] here;
    int before_n;
    here     = exlex_pkg::START_W'(pos);
    before_n = expected_q.size();
    if ((mode == RUN_WORD && alpha(c)) || (mode == RUN_DIGITS && numeral(c))) begin
      // run continues, nothing emitted
      if (run_len != exlex_pkg::LEN_MAX) run_len = run_len + 1'b1;
      if (mode == RUN_WORD) step_keyword(c);
      pos = pos + 1'b1;
    end else begin
      if (mode == RUN_WORD) begin
        push_token(kw_prog == exlex_pkg::KW_DONE ? exlex_pkg::TK_WITH : exlex_pkg::TK_IDENT,
                   run_start, run_len);
      end else if (mode == RUN_DIGITS) begin
        push_token(exlex_pkg::TK_NUMBER, run_start, run_len);
      end
      mode    = RUN_NONE;
      run_len = '0;
      kw_prog = '0;
      if (c == 8'h00) begin
        push_token(exlex_pkg::TK_END, here, '0);
        run_start = '0;
        pos       = '0;
      end else begin
        if (alpha(c)) begin
          mode      = RUN_WORD;
          run_start = here;
          run_len   = exlex_pkg::LEN_W'(1);
          step_keyword(c);
        end else if (numeral(c)) begin
          mode      = RUN_DIGITS;
          run_start = here;
          run_len   = exlex_pkg::LEN_W'(1);
        end else if (!blank(c)) begin
          push_token(punct_kind(c), here, exlex_pkg::LEN_W'(1));
        end
        pos = pos + 1'b1;
      end
      if (expected_q.size() > before_n) expected_q[$].last = 1'b1;
    end
  endfunction

  function void check_token(exlex_pkg::kind_t k, logic [exlex_pkg::START_W-1:0] s,
                            logic [exlex_pkg::LEN_W-1:0] l, logic lst);
    exlex_pkg::token_t want;
    tokens_checked++;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 20)
        $display("%0t: unexpected token: expected none, got kind=%0d start=%0d len=%0d last=%0b",
                 $time, k, s, l, lst);
    end else begin
      want = expected_q.pop_front();
      if (want.kind !== k || want.start !== s || want.len !== l || want.last !== lst) begin
        errors++;
        if (errors <= 20)
          $display({"%0t: token mismatch: expected kind=%0d start=%0d len=%0d last=%0b,",
                    " got kind=%0d start=%0d len=%0d last=%0b"},
                   $time, want.kind, want.start, want.len, want.last, k, s, l, lst);
      end
    end
  endfunction
endclass

module tb_top;
  import exlex_pkg::*;

  localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake before giving up
  localparam int RANDOM_BYTES = 370;

  typedef enum logic [1:0] {SINK_FREE, SINK_CHOPPY, SINK_SLOW} sink_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [15:0] token_start, [31:16] token_length
  logic [3:0]  out_tuser;            // [3:0] token_kind
  logic        out_tlast;

  token_scoreboard sb = new();

  int         bytes_sent = 0;
  int         burst_left = 1;
  sink_mode_e sink_mode  = SINK_FREE;
  int         sink_left  = 0;

  logic [7:0] ops [8]  = '{"+", "-", "*", "/", "(", ")", ":", ","};
  logic [7:0] ws  [6]  = '{" ", "\t", "\n", "\v", "\f", "\r"};
  string      kw_like [5] = '{"with", "wit", "withh", "wIth", "with"};

  expression_lexer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Monitor: every accepted input word feeds the predictor, every accepted
  // token is checked. Both read pre-edge values, so process order is moot.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready)
        sb.check_token(kind_t'(out_tuser), out_tdata[15:0], out_tdata[31:16], out_tlast);
    end
  end

  // Sink back-pressure: the mode is redrawn at random intervals, so free
  // running stretches alternate with choppy and mostly stalled ones.
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 2));
      sink_left <= $urandom_range(50, 400);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_FREE:   out_tready <= 1'b1;
      SINK_CHOPPY: out_tready <= ($urandom_range(0, 3) != 0);
      default:     out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Drive one word and hold it until taken. Words go out in bursts; at the
  // end of a burst valid drops for a random gap and a new length is drawn.
  task automatic send_byte(input logic [7:0] c);
    in_tdata  <= c;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + 8'($urandom_range(0, 25));
  endfunction

  // Random part: mostly well-formed token text, with some noise, high bytes
  // and an occasional end-of-input byte.
  task automatic send_random(input int count);
    int stop_at;
    int pick;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 8)) send_byte(rand_letter());
      end else if (pick < 37) begin
        send_text(kw_like[$urandom_range(0, 4)]);
      end else if (pick < 52) begin
        repeat ($urandom_range(1, 6)) send_byte("0" + 8'($urandom_range(0, 9)));
      end else if (pick < 70) begin
        send_byte(ops[$urandom_range(0, 7)]);
      end else if (pick < 82) begin
        send_byte(ws[$urandom_range(0, 5)]);
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(1, 255)));
      end else if (pick < 94) begin
        send_byte(8'($urandom_range(128, 255)));
      end else begin
        send_byte(8'h00);
      end
    end
  endtask

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d tokens still expected",
             IDLE_LIMIT, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: keyword closed by an operator (two tokens), letter and digit
    // extremes, every operator, every whitespace, end with and without a run.
    send_text("with+Az-09*");
    send_byte(8'h00);
    send_text("Zwith/a9(");
    send_text(")9:");
    send_text(" \t\n\v\f\r");
    send_text(",wit");
    send_byte(8'h00);                 // run flushed, then end token
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("wi ");                 // run closed by whitespace: one token

    send_random(RANDOM_BYTES);

    send_random(40);
    send_byte(8'h00);
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input bytes and %0d tokens: %0d keywords, %0d end markers,",
             bytes_sent, sb.tokens_checked, sb.keywords, sb.end_marks);
    $display("under bursty input and a stalling sink, with %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
